>>> sv/zone_fan_pwm_slew_limiter_assert.svh
// ----------------------------------------------------------------------------
// Zone fan PWM slew limiter assertion macros
// Shorthand for clocked checks with the block's clk and rst.
// ----------------------------------------------------------------------------
`ifndef ZONE_FAN_PWM_SLEW_LIMITER_ASSERT_SVH
`define ZONE_FAN_PWM_SLEW_LIMITER_ASSERT_SVH

// same-cycle implication
`define ZFPS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("zfps: assertion failed");

// next-cycle implication
`define ZFPS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zfps: assertion failed");

`endif

>>> sv/zfps_pkg.sv
// ----------------------------------------------------------------------------
// zfps_pkg
// Types, constants and helpers shared by the zone fan PWM slew limiter.
// ----------------------------------------------------------------------------
package zfps_pkg;

  localparam int MAX_SOURCES = 16;
  localparam int START_PWM   = 0;

  localparam int PCT_W   = 7;
  localparam int RAW_W   = 8;
  localparam int DATA_W  = 8;
  localparam int IDX_W   = 3;
  localparam int CNT_W   = $clog2(MAX_SOURCES + 1);
  localparam int SUM_W   = PCT_W + $clog2(MAX_SOURCES);
  localparam int REM_W   = $clog2(2 * MAX_SOURCES) + 1;
  localparam int DIV_W   = $clog2(SUM_W);
  localparam int NUM_W   = 15;
  localparam int RCP_W   = 13;
  localparam int RCP_SH  = 19;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [PCT_W-1:0] PCT_FULL  = PCT_W'(100);
  // floor(x/100) == (x * 5243) >> 19 for every x below 2^15
  localparam logic [RCP_W-1:0] RECIP_100 = RCP_W'(5243);

  typedef enum logic [IDX_W-1:0] {
    REG_ZONE_MODE   = 3'd0,
    REG_SLEW_STEP   = 3'd1,
    REG_PWM_UPPER   = 3'd2,
    REG_PWM_LOWER   = 3'd3,
    REG_BOOST_FLOOR = 3'd4,
    REG_HOLD_PWM    = 3'd5,
    REG_RAW_MIN     = 3'd6,
    REG_RAW_MAX     = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_MAX = 2'd0,
    MODE_MIN = 2'd1,
    MODE_AVG = 2'd2,
    MODE_OFF = 2'd3
  } zone_mode_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_ZONE,
    B_FAN,
    B_MUL_HI,
    B_MUL_LO,
    B_RECIP,
    B_OUT
  } back_state_t;

  typedef struct packed {
    zone_mode_t         zone_mode;
    logic [PCT_W-1:0]   slew_step;
    logic [PCT_W-1:0]   pwm_upper;
    logic [PCT_W-1:0]   pwm_lower;
    logic [PCT_W-1:0]   boost_floor;
    logic signed [7:0]  hold_pwm;
    logic [RAW_W-1:0]   raw_min;
    logic [RAW_W-1:0]   raw_max;
  } cfg_t;

  // one finished zone accumulation
  typedef struct packed {
    logic [SUM_W-1:0] value;
    logic [CNT_W-1:0] count;
    logic             boost;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [PCT_W-1:0] sat100(input logic [PCT_W-1:0] v);
    return (v > PCT_FULL) ? PCT_FULL : v;
  endfunction

endpackage

>>> sv/zone_fan_pwm_slew_limiter.sv
// ----------------------------------------------------------------------------
// Zone fan PWM slew limiter
// Aggregates per-source demands into a zone value and drives a fan duty.
// ----------------------------------------------------------------------------
// Input channel: one item per source (demand, present, last, boost); the item
// with last set closes a zone update and produces exactly one result.
// Output channel: zone_pwm, fan_pwm and raw_pwm of that update.
// Items that are not last are taken one per cycle while the queue is not
// full. A closed update goes through a two-entry queue to the back end,
// which then steps through its zone, fan, multiply, reciprocal and output
// states (in average mode an 11-step shift and subtract divider first forms
// sum / count). The back end handles one update at a time.
// in_stall rises only when the queue is full; out_stall holds the result in
// the output register and the back end waits, the front keeps accumulating.
// Configuration registers are written through wr_en, wr_index, wr_data and
// should change only while no update is in flight.
// Reset clears the accumulation, the queue and out_valid, restores the
// register defaults and sets the current fan percentage to its start value.
// ----------------------------------------------------------------------------
module zone_fan_pwm_slew_limiter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [zfps_pkg::PCT_W-1:0]  demand,
  input  logic                        present,
  input  logic                        last,
  input  logic                        boost,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [zfps_pkg::PCT_W-1:0]  zone_pwm,
  output logic [zfps_pkg::PCT_W-1:0]  fan_pwm,
  output logic [zfps_pkg::RAW_W-1:0]  raw_pwm,
  input  logic                        wr_en,
  input  logic [zfps_pkg::IDX_W-1:0]  wr_index,
  input  logic [zfps_pkg::DATA_W-1:0] wr_data
);

  zfps_pkg::cfg_t    cfg;
  zfps_pkg::rec_t    rec, head;
  zfps_pkg::q_stat_t qstat;
  logic              push, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zone_mode   <= zfps_pkg::MODE_MAX;
      cfg.slew_step   <= '0;
      cfg.pwm_upper   <= zfps_pkg::PCT_FULL;
      cfg.pwm_lower   <= '0;
      cfg.boost_floor <= zfps_pkg::PCT_FULL;
      cfg.hold_pwm    <= -8'sd1;
      cfg.raw_min     <= '0;
      cfg.raw_max     <= '1;
    end else if (wr_en) begin
      unique case (zfps_pkg::reg_idx_t'(wr_index))
        zfps_pkg::REG_ZONE_MODE:   cfg.zone_mode   <= zfps_pkg::zone_mode_t'(wr_data[1:0]);
        zfps_pkg::REG_SLEW_STEP:   cfg.slew_step   <= wr_data[zfps_pkg::PCT_W-1:0];
        zfps_pkg::REG_PWM_UPPER:   cfg.pwm_upper   <= wr_data[zfps_pkg::PCT_W-1:0];
        zfps_pkg::REG_PWM_LOWER:   cfg.pwm_lower   <= wr_data[zfps_pkg::PCT_W-1:0];
        zfps_pkg::REG_BOOST_FLOOR: cfg.boost_floor <= wr_data[zfps_pkg::PCT_W-1:0];
        zfps_pkg::REG_HOLD_PWM:    cfg.hold_pwm    <= $signed(wr_data);
        zfps_pkg::REG_RAW_MIN:     cfg.raw_min     <= wr_data;
        zfps_pkg::REG_RAW_MAX:     cfg.raw_max     <= wr_data;
      endcase
    end
  end

  zfps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .demand    (demand),
    .present   (present),
    .last      (last),
    .boost     (boost),
    .zone_mode (cfg.zone_mode),
    .qstat     (qstat),
    .push      (push),
    .rec       (rec)
  );

  zfps_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_rec (rec),
    .pop    (pop),
    .head   (head),
    .qstat  (qstat)
  );

  zfps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .zone_pwm  (zone_pwm),
    .fan_pwm   (fan_pwm),
    .raw_pwm   (raw_pwm)
  );

`include "zone_fan_pwm_slew_limiter_assert.svh"

  `ZFPS_ASSERT_IMP(a_queue_no_overflow, push, !qstat.full)
  `ZFPS_ASSERT_NXT(a_push_fills_queue, push && qstat.empty, !qstat.empty)
  `ZFPS_ASSERT_IMP(a_pct_in_range, out_valid, fan_pwm <= 7'd100 && zone_pwm <= 7'd100)
  `ZFPS_ASSERT_IMP(a_raw_in_range, out_valid && cfg.raw_min <= cfg.raw_max,
                   raw_pwm >= cfg.raw_min && raw_pwm <= cfg.raw_max)

endmodule

>>> sv/zfps_front.sv
// ----------------------------------------------------------------------------
// zfps_front
// Accepts source items and folds present demands into a running value.
// ----------------------------------------------------------------------------
module zfps_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [zfps_pkg::PCT_W-1:0] demand,
  input  logic                       present,
  input  logic                       last,
  input  logic                       boost,
  input  zfps_pkg::zone_mode_t       zone_mode,
  input  zfps_pkg::q_stat_t          qstat,
  output logic                       push,
  output zfps_pkg::rec_t             rec
);

  logic [zfps_pkg::SUM_W-1:0] value, value_next, val_fold;
  logic [zfps_pkg::CNT_W-1:0] count, count_next, cnt_fold;
  logic [zfps_pkg::PCT_W-1:0] dem;
  logic                       take, acc;

  assign in_stall = qstat.full;
  assign acc      = in_valid && !in_stall;

  always_comb begin
    dem      = zfps_pkg::sat100(demand);
    take     = present && (count < zfps_pkg::CNT_W'(zfps_pkg::MAX_SOURCES));
    val_fold = value;
    unique case (zone_mode)
      zfps_pkg::MODE_MAX: begin
        if (count == '0 || zfps_pkg::SUM_W'(dem) > value) val_fold = zfps_pkg::SUM_W'(dem);
      end
      zfps_pkg::MODE_MIN: begin
        if (count == '0 || zfps_pkg::SUM_W'(dem) < value) val_fold = zfps_pkg::SUM_W'(dem);
      end
      zfps_pkg::MODE_AVG: val_fold = value + zfps_pkg::SUM_W'(dem);
      zfps_pkg::MODE_OFF: val_fold = value;
    endcase
    if (!take) val_fold = value;
    cnt_fold = take ? count + zfps_pkg::CNT_W'(1) : count;

    push      = acc && last;
    rec.value = val_fold;
    rec.count = cnt_fold;
    rec.boost = boost;

    value_next = value;
    count_next = count;
    if (acc) begin
      // a zone update ends on the last item and accumulation restarts
      value_next = last ? '0 : val_fold;
      count_next = last ? '0 : cnt_fold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
      count <= '0;
    end else begin
      value <= value_next;
      count <= count_next;
    end
  end

endmodule

>>> sv/zfps_queue.sv
// ----------------------------------------------------------------------------
// zfps_queue
// Short FIFO of finished zone records between the front and back parts.
// ----------------------------------------------------------------------------
module zfps_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  zfps_pkg::rec_t    wr_rec,
  input  logic              pop,
  output zfps_pkg::rec_t    head,
  output zfps_pkg::q_stat_t qstat
);

  zfps_pkg::rec_t              entries [zfps_pkg::QDEPTH];
  logic [zfps_pkg::QPTR_W-1:0] wptr, rptr;
  logic [zfps_pkg::QCNT_W-1:0] fill;

  assign head        = entries[rptr];
  assign qstat.full  = (fill == zfps_pkg::QCNT_W'(zfps_pkg::QDEPTH));
  assign qstat.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (push) entries[wptr] <= wr_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= (wptr == zfps_pkg::QPTR_W'(zfps_pkg::QDEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == zfps_pkg::QPTR_W'(zfps_pkg::QDEPTH - 1)) ? '0 : rptr + 1'b1;
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> sv/zfps_back.sv
// ----------------------------------------------------------------------------
// zfps_back
// Forms the zone value, applies slew, clamps and hold, scales to raw duty.
// ----------------------------------------------------------------------------
module zfps_back (
  input  logic                       clk,
  input  logic                       rst,
  input  zfps_pkg::cfg_t             cfg,
  input  zfps_pkg::rec_t             head,
  input  zfps_pkg::q_stat_t          qstat,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [zfps_pkg::PCT_W-1:0] zone_pwm,
  output logic [zfps_pkg::PCT_W-1:0] fan_pwm,
  output logic [zfps_pkg::RAW_W-1:0] raw_pwm
);

  localparam int QM_W = zfps_pkg::NUM_W + zfps_pkg::RCP_W;

  zfps_pkg::back_state_t state, state_next;

  logic [zfps_pkg::SUM_W-1:0] rv, dq;
  logic [zfps_pkg::CNT_W-1:0] cnt;
  logic                       bst;
  logic [zfps_pkg::REM_W-1:0] rem, rem_t;
  logic [zfps_pkg::DIV_W-1:0] step_cnt;
  logic                       ge;
  logic [zfps_pkg::PCT_W-1:0] zone, fan, cur;
  logic [zfps_pkg::NUM_W-1:0] num;
  logic [QM_W-1:0]            qm;

  logic [zfps_pkg::SUM_W-1:0] zsel;
  logic [zfps_pkg::PCT_W-1:0] bfl, zone_c;
  logic [zfps_pkg::PCT_W-1:0] stp, up, lo, diff, fan_c;
  logic [zfps_pkg::PCT_W:0]   up_sum;
  logic [8:0]                 v;
  logic [zfps_pkg::RAW_W-1:0] raw_c;
  logic                       load_out;

  // restoring divide step
  always_comb begin
    rem_t = {rem[zfps_pkg::REM_W-2:0], dq[zfps_pkg::SUM_W-1]};
    ge    = (rem_t >= zfps_pkg::REM_W'(cnt));
  end

  // zone value after mode and boost
  always_comb begin
    zsel = '0;
    if (cnt != '0) begin
      unique case (cfg.zone_mode)
        zfps_pkg::MODE_MAX, zfps_pkg::MODE_MIN: zsel = rv;
        zfps_pkg::MODE_AVG:                     zsel = dq;
        zfps_pkg::MODE_OFF:                     zsel = '0;
      endcase
    end
    bfl = zfps_pkg::sat100(cfg.boost_floor);
    if (bst && zsel < zfps_pkg::SUM_W'(bfl)) zsel = zfps_pkg::SUM_W'(bfl);
    zone_c = (zsel > zfps_pkg::SUM_W'(zfps_pkg::PCT_FULL)) ? zfps_pkg::PCT_FULL
                                                          : zsel[zfps_pkg::PCT_W-1:0];
  end

  // slew toward the zone value, then clamp and hold
  always_comb begin
    stp    = zfps_pkg::sat100(cfg.slew_step);
    up     = zfps_pkg::sat100(cfg.pwm_upper);
    lo     = zfps_pkg::sat100(cfg.pwm_lower);
    diff   = (cur > zone) ? cur - zone : zone - cur;
    up_sum = {1'b0, cur} + {1'b0, stp};
    fan_c  = zone;
    if (stp != '0 && cur != '0 && diff > stp) begin
      fan_c = (zone > cur) ? up_sum[zfps_pkg::PCT_W-1:0] : cur - stp;
    end
    if (fan_c > up) fan_c = up;
    if (fan_c < lo) fan_c = lo;
    if (!cfg.hold_pwm[7]) fan_c = zfps_pkg::sat100(cfg.hold_pwm[zfps_pkg::PCT_W-1:0]);
  end

  // raw duty clamp, low bound first
  always_comb begin
    v = qm[zfps_pkg::RCP_SH +: 9];
    if (v < {1'b0, cfg.raw_min}) begin
      raw_c = cfg.raw_min;
    end else if (v > {1'b0, cfg.raw_max}) begin
      raw_c = cfg.raw_max;
    end else begin
      raw_c = v[zfps_pkg::RAW_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      zfps_pkg::B_IDLE: begin
        if (!qstat.empty) begin
          pop = 1'b1;
          state_next = (cfg.zone_mode == zfps_pkg::MODE_AVG && head.count != '0)
                       ? zfps_pkg::B_DIV : zfps_pkg::B_ZONE;
        end
      end
      zfps_pkg::B_DIV: begin
        if (step_cnt == zfps_pkg::DIV_W'(zfps_pkg::SUM_W - 1)) state_next = zfps_pkg::B_ZONE;
      end
      zfps_pkg::B_ZONE:   state_next = zfps_pkg::B_FAN;
      zfps_pkg::B_FAN:    state_next = zfps_pkg::B_MUL_HI;
      zfps_pkg::B_MUL_HI: state_next = zfps_pkg::B_MUL_LO;
      zfps_pkg::B_MUL_LO: state_next = zfps_pkg::B_RECIP;
      zfps_pkg::B_RECIP:  state_next = zfps_pkg::B_OUT;
      zfps_pkg::B_OUT: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = zfps_pkg::B_IDLE;
        end
      end
      default: state_next = zfps_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= zfps_pkg::B_IDLE;
      out_valid <= 1'b0;
      cur       <= zfps_pkg::PCT_W'(zfps_pkg::START_PWM);
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == zfps_pkg::B_FAN) cur <= fan_c;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      zfps_pkg::B_IDLE: begin
        rv       <= head.value;
        cnt      <= head.count;
        bst      <= head.boost;
        dq       <= head.value;
        rem      <= '0;
        step_cnt <= '0;
      end
      zfps_pkg::B_DIV: begin
        dq       <= {dq[zfps_pkg::SUM_W-2:0], ge};
        rem      <= ge ? rem_t - zfps_pkg::REM_W'(cnt) : rem_t;
        step_cnt <= step_cnt + 1'b1;
      end
      zfps_pkg::B_ZONE: zone <= zone_c;
      zfps_pkg::B_FAN:  fan  <= fan_c;
      // num = raw_max * pct + raw_min * (100 - pct), never above 25500
      zfps_pkg::B_MUL_HI: num <= zfps_pkg::NUM_W'(cfg.raw_max * fan);
      zfps_pkg::B_MUL_LO: num <= num + zfps_pkg::NUM_W'(cfg.raw_min * (zfps_pkg::PCT_FULL - fan));
      zfps_pkg::B_RECIP:  qm  <= num * zfps_pkg::RECIP_100;
      zfps_pkg::B_OUT: begin
        if (load_out) begin
          zone_pwm <= zone;
          fan_pwm  <= fan;
          raw_pwm  <= raw_c;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> tb/zone_pwm_checker.sv
// ----------------------------------------------------------------------------
// Zone PWM result checker
// Watches the register port and both item channels of the slew limiter.
// It keeps its own copy of the registers and the zone and fan state, and
// works out the result of every closing item. Each accepted result is
// compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module zone_pwm_checker
  import zfps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [PCT_W-1:0]  demand,
  input  logic              present,
  input  logic              last,
  input  logic              boost,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [PCT_W-1:0]  zone_pwm,
  input  logic [PCT_W-1:0]  fan_pwm,
  input  logic [RAW_W-1:0]  raw_pwm,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_index,
  input  logic [DATA_W-1:0] wr_data,
  output int                fail_count,
  output int                pending,
  output int                results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PCT_W-1:0] zone;
    logic [PCT_W-1:0] fan;
    logic [RAW_W-1:0] raw;
  } duty_result_t;

  duty_result_t     duty_q[$];
  cfg_t             cfg;
  logic [SUM_W-1:0] zone_acc;
  int               src_count;
  int               fan_now;
  int               fails;
  int               checked;

  function automatic int cap_pct(input int v);
    return (v > 100) ? 100 : v;
  endfunction

  // fold one source in; a closing item yields the expected duty result
  task automatic predict_duty(input logic [PCT_W-1:0] d, input logic p, input logic l,
                              input logic b);
    int           dem;
    int           z;
    int           f;
    int           step;
    int           gap;
    int           lo;
    int           hi;
    int           r;
    duty_result_t res;
    dem = cap_pct(int'(d));
    if (p && src_count < MAX_SOURCES) begin
      case (cfg.zone_mode)
        MODE_MAX: if (src_count == 0 || dem > int'(zone_acc)) zone_acc = SUM_W'(dem);
        MODE_MIN: if (src_count == 0 || dem < int'(zone_acc)) zone_acc = SUM_W'(dem);
        MODE_AVG: zone_acc = zone_acc + SUM_W'(dem);
        default: ;
      endcase
      src_count++;
    end
    if (l) begin
      z = 0;
      if (src_count != 0) begin
        if (cfg.zone_mode == MODE_MAX || cfg.zone_mode == MODE_MIN) begin
          z = int'(zone_acc);
        end else if (cfg.zone_mode == MODE_AVG) begin
          z = int'(zone_acc) / src_count;
        end
      end
      if (b && z < cap_pct(int'(cfg.boost_floor))) z = cap_pct(int'(cfg.boost_floor));
      z = cap_pct(z);
      // slew toward the zone value, jump when unlimited or fan stopped
      step = cap_pct(int'(cfg.slew_step));
      gap = (fan_now > z) ? fan_now - z : z - fan_now;
      if (step == 0 || fan_now == 0 || gap <= step) begin
        f = z;
      end else begin
        f = (z > fan_now) ? fan_now + step : fan_now - step;
      end
      if (f > cap_pct(int'(cfg.pwm_upper))) f = cap_pct(int'(cfg.pwm_upper));
      if (f < cap_pct(int'(cfg.pwm_lower))) f = cap_pct(int'(cfg.pwm_lower));
      if (!cfg.hold_pwm[7]) f = cap_pct(int'(cfg.hold_pwm[6:0]));
      fan_now = f;
      lo = int'(cfg.raw_min);
      hi = int'(cfg.raw_max);
      r = ((hi - lo) * f + 100 * lo) / 100;
      if (r < lo) begin
        r = lo;
      end else if (r > hi) begin
        r = hi;
      end
      res.zone = PCT_W'(z);
      res.fan  = PCT_W'(f);
      res.raw  = RAW_W'(r);
      duty_q.push_back(res);
      zone_acc  = '0;
      src_count = 0;
    end
  endtask

  task automatic check_duty();
    duty_result_t exp_res;
    if (duty_q.size() == 0) begin
      fails++;
      if (fails <= 10) begin
        $display("%0t: result with nothing expected: zone %0d fan %0d raw %0d",
                 $realtime, zone_pwm, fan_pwm, raw_pwm);
      end
    end else begin
      exp_res = duty_q.pop_front();
      checked++;
      if (exp_res.zone !== zone_pwm || exp_res.fan !== fan_pwm || exp_res.raw !== raw_pwm)
      begin
        fails++;
        if (fails <= 10) begin
          $display("%0t: mismatch zone %0d/%0d fan %0d/%0d raw %0d/%0d (exp/act)",
                   $realtime, exp_res.zone, zone_pwm, exp_res.fan, fan_pwm,
                   exp_res.raw, raw_pwm);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg.zone_mode   = MODE_MAX;
      cfg.slew_step   = '0;
      cfg.pwm_upper   = PCT_W'(100);
      cfg.pwm_lower   = '0;
      cfg.boost_floor = PCT_W'(100);
      cfg.hold_pwm    = 8'hFF;
      cfg.raw_min     = '0;
      cfg.raw_max     = 8'hFF;
      zone_acc        = '0;
      src_count       = 0;
      fan_now         = START_PWM;
      duty_q.delete();
      fails           = 0;
      checked         = 0;
    end else begin
      if (wr_en) begin
        case (reg_idx_t'(wr_index))
          REG_ZONE_MODE:   cfg.zone_mode   = zone_mode_t'(wr_data[1:0]);
          REG_SLEW_STEP:   cfg.slew_step   = wr_data[PCT_W-1:0];
          REG_PWM_UPPER:   cfg.pwm_upper   = wr_data[PCT_W-1:0];
          REG_PWM_LOWER:   cfg.pwm_lower   = wr_data[PCT_W-1:0];
          REG_BOOST_FLOOR: cfg.boost_floor = wr_data[PCT_W-1:0];
          REG_HOLD_PWM:    cfg.hold_pwm    = wr_data;
          REG_RAW_MIN:     cfg.raw_min     = wr_data;
          REG_RAW_MAX:     cfg.raw_max     = wr_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_duty(demand, present, last, boost);
      if (out_valid && !out_stall) check_duty();
    end
    fail_count   <= fails;
    pending      <= duty_q.size();
    results_seen <= checked;
  end

endmodule

>>> tb/zone_fan_pwm_slew_limiter_tb.sv
// ----------------------------------------------------------------------------
// Zone fan PWM slew limiter testbench
// Drives zone updates of random length and content through the limiter
// under many register settings and three idling patterns, including a long
// output hold-off. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module zone_fan_pwm_slew_limiter_tb;
  import zfps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 30;
  localparam int ITEMS_PER_SETTING = 128;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [PCT_W-1:0]  demand;
  logic              present;
  logic              last;
  logic              boost;
  logic              out_valid;
  logic              out_stall;
  logic [PCT_W-1:0]  zone_pwm;
  logic [PCT_W-1:0]  fan_pwm;
  logic [RAW_W-1:0]  raw_pwm;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_index;
  logic [DATA_W-1:0] wr_data;

  int fail_count;
  int pending;
  int results_seen;

  int snd_idle = 27;
  int rcv_idle = 76;
  int hold_requests = 0;
  int items_sent = 0;
  int updates_sent = 0;
  int settings_used = 0;

  zone_fan_pwm_slew_limiter uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .demand(demand), .present(present), .last(last), .boost(boost),
    .out_valid(out_valid), .out_stall(out_stall),
    .zone_pwm(zone_pwm), .fan_pwm(fan_pwm), .raw_pwm(raw_pwm),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  zone_pwm_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .demand(demand), .present(present), .last(last), .boost(boost),
    .out_valid(out_valid), .out_stall(out_stall),
    .zone_pwm(zone_pwm), .fan_pwm(fan_pwm), .raw_pwm(raw_pwm),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // result side: random stall, plus a long hold-off on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(0, 99) < rcv_idle);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || wr_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("zone_fan_pwm_slew_limiter_tb failed");
    $finish;
  end

  // valid stays high from one item to the next unless an idle cycle is drawn
  task automatic send_item(input logic [PCT_W-1:0] d, input logic p, input logic l,
                           input logic b);
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    demand   = d;
    present  = p;
    last     = l;
    boost    = b;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (l) updates_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] v);
    @(negedge clk);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = v;
  endtask

  task automatic set_config(input zone_mode_t mode, input logic [7:0] slew,
                            input logic [7:0] upper, input logic [7:0] lower,
                            input logic [7:0] floor_pct, input logic [7:0] hold,
                            input logic [7:0] rmin, input logic [7:0] rmax);
    write_reg(REG_ZONE_MODE, DATA_W'(mode));
    write_reg(REG_SLEW_STEP, slew);
    write_reg(REG_PWM_UPPER, upper);
    write_reg(REG_PWM_LOWER, lower);
    write_reg(REG_BOOST_FLOOR, floor_pct);
    write_reg(REG_HOLD_PWM, hold);
    write_reg(REG_RAW_MIN, rmin);
    write_reg(REG_RAW_MAX, rmax);
    @(negedge clk);
    wr_en = 1'b0;
    settings_used++;
  endtask

  task automatic pick_setting(input int k);
    logic [7:0] slew;
    logic [7:0] upper;
    logic [7:0] lower;
    logic [7:0] hold;
    logic [7:0] rmin;
    logic [7:0] rmax;
    logic [7:0] tmp;
    case (k)
      0: set_config(MODE_MAX, 8'd1, 8'd127, 8'd0, 8'd0, 8'h80, 8'd0, 8'd255);
      1: set_config(MODE_AVG, 8'd127, 8'd0, 8'd127, 8'd127, 8'd127, 8'd255, 8'd255);
      2: set_config(MODE_MIN, 8'd0, 8'd100, 8'd100, 8'd100, 8'd0, 8'd255, 8'd0);
      default: begin
        case ($urandom_range(0, 4))
          0: slew = 8'd0;
          1: slew = 8'd1;
          2: slew = 8'd100;
          3: slew = 8'($urandom_range(101, 127));
          default: slew = 8'($urandom_range(2, 30));
        endcase
        upper = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(50, 100))
                                           : 8'($urandom_range(0, 127));
        lower = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, 40))
                                           : 8'($urandom_range(0, 127));
        if ($urandom_range(0, 3) != 0) begin
          hold = 8'hFF;
        end else begin
          hold = $urandom_range(0, 1) ? 8'($urandom_range(0, 127))
                                      : 8'($urandom_range(128, 255));
        end
        rmin = 8'($urandom_range(0, 255));
        rmax = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) < 6 && rmin > rmax) begin
          tmp  = rmin;
          rmin = rmax;
          rmax = tmp;
        end
        set_config(zone_mode_t'(k % 4), slew, upper, lower, 8'($urandom_range(0, 127)),
                   hold, rmin, rmax);
      end
    endcase
  endtask

  // mostly short updates, some past the source limit, a few with no source
  task automatic send_random_update(output int n);
    int present_pct;
    logic [PCT_W-1:0] d;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
    present_pct = ($urandom_range(0, 19) == 0) ? 0 : 85;
    for (int i = 0; i < n; i++) begin
      d = ($urandom_range(0, 9) == 0) ? PCT_W'($urandom_range(101, 127))
                                      : PCT_W'($urandom_range(0, 100));
      send_item(d, ($urandom_range(0, 99) < present_pct), (i == n - 1),
                1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int count;
    int n;
    bit paused;
    in_valid = 1'b0;
    demand   = '0;
    present  = 1'b0;
    last     = 1'b0;
    boost    = 1'b0;
    wr_en    = 1'b0;
    wr_index = '0;
    wr_data  = '0;
    paused   = 1'b0;
    rst      = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed updates under reset registers: max mode, no source, boost
    send_item(7'd0, 1'b1, 1'b1, 1'b0);
    send_item(7'd100, 1'b1, 1'b0, 1'b0);
    send_item(7'd127, 1'b1, 1'b0, 1'b0);
    send_item(7'd5, 1'b1, 1'b1, 1'b0);
    send_item(7'd50, 1'b0, 1'b0, 1'b0);
    send_item(7'd60, 1'b0, 1'b1, 1'b1);
    send_item(7'd60, 1'b0, 1'b1, 1'b0);
    drain();
    // min from the first demand, then slew limited moves and boost floor
    set_config(MODE_MIN, 8'd10, 8'd90, 8'd5, 8'd30, 8'hFF, 8'd20, 8'd200);
    send_item(7'd40, 1'b1, 1'b0, 1'b0);
    send_item(7'd127, 1'b1, 1'b0, 1'b0);
    send_item(7'd70, 1'b1, 1'b1, 1'b0);
    send_item(7'd90, 1'b1, 1'b1, 1'b0);
    send_item(7'd0, 1'b1, 1'b1, 1'b1);
    drain();
    // average with a skipped source, reversed raw range
    set_config(MODE_AVG, 8'd0, 8'd100, 8'd0, 8'd100, 8'hFF, 8'd255, 8'd0);
    send_item(7'd10, 1'b1, 1'b0, 1'b0);
    send_item(7'd11, 1'b1, 1'b0, 1'b0);
    send_item(7'd13, 1'b0, 1'b0, 1'b0);
    send_item(7'd12, 1'b1, 1'b1, 1'b0);
    drain();
    // off mode, oversized registers and hold
    set_config(MODE_OFF, 8'd5, 8'd120, 8'd110, 8'd120, 8'd120, 8'd0, 8'd255);
    send_item(7'd80, 1'b1, 1'b0, 1'b0);
    send_item(7'd80, 1'b1, 1'b1, 1'b1);
    drain();
    // lower clamp above upper, negative hold other than -1
    set_config(MODE_MAX, 8'd0, 8'd30, 8'd60, 8'd0, 8'h9C, 8'd0, 8'd255);
    send_item(7'd45, 1'b1, 1'b1, 1'b0);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin snd_idle = 27; rcv_idle = 76; end
        1: begin snd_idle = 76; rcv_idle = 27; end
        default: begin snd_idle = 0; rcv_idle = 0; end
      endcase
      for (int s = 0; s < 4; s++) begin
        drain();
        pick_setting(ph * 4 + s);
        // receiver holds off while updates keep coming, so the input stalls
        if (ph == 2 && s == 1) hold_requests++;
        count = 0;
        while (count < ITEMS_PER_SETTING) begin
          if (ph == 1 && s == 2 && !paused && count >= ITEMS_PER_SETTING / 2) begin
            drain();
            paused = 1'b1;
          end
          send_random_update(n);
          count += n;
        end
      end
    end
    drain();

    $display("covered %0d items in %0d zone updates over %0d register settings",
             items_sent, updates_sent, settings_used);
    $display("%0d results checked, %0d failures", results_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("zone_fan_pwm_slew_limiter_tb passed");
    end else begin
      $display("zone_fan_pwm_slew_limiter_tb failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/zfps_pkg.sv
sv/zfps_front.sv
sv/zfps_queue.sv
sv/zfps_back.sv
sv/zone_fan_pwm_slew_limiter.sv
tb/zone_pwm_checker.sv
tb/zone_fan_pwm_slew_limiter_tb.sv
